### hdl/asr_pkg.sv
// Shared types, widths and codes for the ADC sample ring with average.
package asr_pkg;

  localparam int unsigned DEPTH_DEF = 64;
  localparam int unsigned MODE_W    = 3;
  localparam int unsigned SAMPLE_W  = 16;
  localparam int unsigned STAMP_W   = 32;
  localparam int unsigned AVG_LEN_W = 7;
  localparam int unsigned COUNT_W   = 6;
  localparam int unsigned RATE_W    = 20;
  localparam int unsigned ENTRY_W   = SAMPLE_W + STAMP_W;
  localparam int unsigned CMD_QD    = 2;

  // Mode codes on the input channel
  localparam logic [MODE_W-1:0] MODE_PUSH   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_POP    = 3'd1;
  localparam logic [MODE_W-1:0] MODE_AVG    = 3'd2;
  localparam logic [MODE_W-1:0] MODE_STATUS = 3'd3;
  localparam logic [MODE_W-1:0] MODE_CLEAR  = 3'd4;

  typedef enum logic [2:0] {
    OP_PUSH,
    OP_POP,
    OP_AVG,
    OP_STAT,
    OP_CLR,
    OP_NOP
  } op_e;

  typedef struct packed {
    logic [MODE_W-1:0]    mode;
    logic [SAMPLE_W-1:0]  sample_value;
    logic [STAMP_W-1:0]   time_stamp;
    logic [AVG_LEN_W-1:0] average_length;
  } in_item_t;

  typedef struct packed {
    logic                valid_result;
    logic [SAMPLE_W-1:0] result_value;
    logic [STAMP_W-1:0]  result_stamp;
    logic [COUNT_W-1:0]  stored_count;
    logic                overflow_seen;
    logic                underflow_seen;
  } out_item_t;

  typedef struct packed {
    op_e                  op;
    logic [SAMPLE_W-1:0]  sample_value;
    logic [STAMP_W-1:0]   time_stamp;
    logic [AVG_LEN_W-1:0] average_length;
  } cmd_t;

endpackage

### hdl/asr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module asr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/asr_front.sv
// Front end: take input transfers, decode the mode and queue commands.
module asr_front import asr_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     cmd_valid_o,
  input  logic     cmd_ready_i,
  output cmd_t     cmd_o
);

  localparam int unsigned QW = (CMD_QD > 1) ? $clog2(CMD_QD) : 1;
  localparam logic [QW-1:0] Q_LAST = QW'(CMD_QD - 1);

  function automatic op_e decode(input logic [MODE_W-1:0] mode);
    op_e op;
    unique case (mode)
      MODE_PUSH:   op = OP_PUSH;
      MODE_POP:    op = OP_POP;
      MODE_AVG:    op = OP_AVG;
      MODE_STATUS: op = OP_STAT;
      MODE_CLEAR:  op = OP_CLR;
      default:     op = OP_NOP;
    endcase
    return op;
  endfunction

  cmd_t          q_mem_q [CMD_QD];
  logic [QW-1:0] wr_q, rd_q;
  logic [QW:0]   fill_q;
  logic          push, pop;
  cmd_t          cmd_new;

  assign in_ready_o  = (fill_q != (QW+1)'(CMD_QD));
  assign cmd_valid_o = (fill_q != '0);
  assign cmd_o       = q_mem_q[rd_q];
  assign push        = in_valid_i && in_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    cmd_new.op             = decode(in_data_i.mode);
    cmd_new.sample_value   = in_data_i.sample_value;
    cmd_new.time_stamp     = in_data_i.time_stamp;
    cmd_new.average_length = in_data_i.average_length;
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem_q[wr_q] <= cmd_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == Q_LAST) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == Q_LAST) ? '0 : rd_q + 1'b1;
      end
      if (push && !pop) begin
        fill_q <= fill_q + 1'b1;
      end else if (pop && !push) begin
        fill_q <= fill_q - 1'b1;
      end
    end
  end

endmodule

### hdl/asr_div.sv
// Restoring divider, one quotient bit per cycle.
module asr_div #(
  parameter int unsigned DVD_W = 23,
  parameter int unsigned DVS_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0] divisor_i,
  output logic             busy_o,
  output logic             done_o,
  output logic [DVD_W-1:0] quot_o
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);

  logic [DVS_W:0]   rem_q;
  logic [DVD_W-1:0] quo_q;
  logic [DVS_W-1:0] dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [DVS_W:0]   shifted;
  logic             ge;

  assign shifted = {rem_q[DVS_W-1:0], quo_q[DVD_W-1]};
  assign ge      = (shifted >= {1'b0, dvs_q});

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? (shifted - {1'b0, dvs_q}) : shifted;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        cnt_q  <= CNT_W'(DVD_W);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### hdl/asr_back.sv
// Back end: ring pointers, flags, sample RAM, averaging walk and result register.
module asr_back import asr_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cmd_valid_i,
  output logic      cmd_ready_o,
  input  cmd_t      cmd_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned PTR_W = $clog2(DEPTH);
  localparam int unsigned N_W   = (PTR_W > AVG_LEN_W) ? PTR_W : AVG_LEN_W;
  localparam int unsigned SUM_W = SAMPLE_W + N_W;
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_POP  = 4'b0010,
    ST_SUM  = 4'b0100,
    ST_DIV  = 4'b1000
  } back_state_e;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [PTR_W-1:0] ring_count(input logic [PTR_W-1:0] wr,
                                                  input logic [PTR_W-1:0] rd);
    logic [PTR_W:0] wrap;
    wrap = {1'b0, wr} + (PTR_W+1)'(DEPTH) - {1'b0, rd};
    return (wr >= rd) ? (wr - rd) : wrap[PTR_W-1:0];
  endfunction

  back_state_e         state_q, state_d;
  logic [PTR_W-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0]    idx_q, idx_d;
  logic                ov_q, ov_d, un_q, un_d;
  logic [N_W-1:0]      k_q, k_d, n_q, n_d;
  logic [SUM_W-1:0]    sum_q, sum_d;
  logic                pend_q, pend_d;
  logic                out_valid_q, out_valid_d;
  out_item_t           out_q, out_d;

  logic                take, res_load, res_valid, status_rd;
  logic [SAMPLE_W-1:0] res_value;
  logic [STAMP_W-1:0]  res_stamp;
  logic [N_W-1:0]      n_ext, cnt_ext;
  logic [PTR_W+5:0]    cnt_wide;

  logic                ram_we;
  logic [PTR_W-1:0]    ram_raddr;
  logic [ENTRY_W-1:0]  ram_rdata;

  logic                div_start, div_busy, div_done;
  logic [SUM_W-1:0]    div_quot;

  asr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i ({cmd_i.sample_value, cmd_i.time_stamp}),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  asr_div #(
    .DVD_W (SUM_W),
    .DVS_W (N_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sum_q),
    .divisor_i  (n_q),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  assign cmd_ready_o = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign take        = cmd_valid_i && cmd_ready_o;
  assign n_ext       = N_W'(cmd_i.average_length);
  assign cnt_ext     = N_W'(ring_count(wr_ptr_q, rd_ptr_q));

  always_comb begin
    state_d     = state_q;
    wr_ptr_d    = wr_ptr_q;
    rd_ptr_d    = rd_ptr_q;
    idx_d       = idx_q;
    ov_d        = ov_q;
    un_d        = un_q;
    k_d         = k_q;
    n_d         = n_q;
    sum_d       = sum_q;
    pend_d      = 1'b0;
    ram_we      = 1'b0;
    ram_raddr   = rd_ptr_q;
    res_load    = 1'b0;
    res_valid   = 1'b0;
    res_value   = '0;
    res_stamp   = '0;
    status_rd   = 1'b0;
    div_start   = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;

    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          unique case (cmd_i.op)
            OP_PUSH: begin
              ram_we   = 1'b1;
              wr_ptr_d = ptr_inc(wr_ptr_q);
              if (ptr_inc(wr_ptr_q) == rd_ptr_q) begin
                rd_ptr_d = ptr_inc(rd_ptr_q);
                ov_d     = 1'b1;
              end
              res_load = 1'b1;
            end
            OP_POP: begin
              if (wr_ptr_q == rd_ptr_q) begin
                un_d     = 1'b1;
                res_load = 1'b1;
              end else begin
                rd_ptr_d = ptr_inc(rd_ptr_q);
                state_d  = ST_POP;
              end
            end
            OP_AVG: begin
              if ((n_ext != '0) && (n_ext <= cnt_ext)) begin
                idx_d   = rd_ptr_q;
                k_d     = '0;
                n_d     = n_ext;
                sum_d   = '0;
                state_d = ST_SUM;
              end else begin
                res_load = 1'b1;
              end
            end
            OP_STAT: begin
              status_rd = 1'b1;
              ov_d      = 1'b0;
              un_d      = 1'b0;
              res_load  = 1'b1;
            end
            OP_CLR: begin
              wr_ptr_d = '0;
              rd_ptr_d = '0;
              res_load = 1'b1;
            end
            default: begin
              res_load = 1'b1;
            end
          endcase
        end
      end
      ST_POP: begin
        res_load  = 1'b1;
        res_valid = 1'b1;
        res_value = ram_rdata[ENTRY_W-1 -: SAMPLE_W];
        res_stamp = ram_rdata[STAMP_W-1:0];
        state_d   = ST_IDLE;
      end
      ST_SUM: begin
        // Issue one read per cycle, add the data that returns in the next cycle
        if (k_q != n_q) begin
          ram_raddr = idx_q;
          idx_d     = ptr_inc(idx_q);
          k_d       = k_q + 1'b1;
          pend_d    = 1'b1;
        end
        if (pend_q) begin
          sum_d = sum_q + SUM_W'(ram_rdata[ENTRY_W-1 -: SAMPLE_W]);
        end
        if ((k_q == n_q) && !pend_q) begin
          div_start = 1'b1;
          state_d   = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done) begin
          res_load  = 1'b1;
          res_valid = 1'b1;
          res_value = div_quot[SAMPLE_W-1:0];
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    cnt_wide = (PTR_W+6)'(ring_count(wr_ptr_d, rd_ptr_d));
    out_d    = out_q;
    if (res_load) begin
      out_valid_d          = 1'b1;
      out_d.valid_result   = res_valid;
      out_d.result_value   = res_value;
      out_d.result_stamp   = res_stamp;
      out_d.stored_count   = cnt_wide[COUNT_W-1:0];
      out_d.overflow_seen  = status_rd ? ov_q : ov_d;
      out_d.underflow_seen = status_rd ? un_q : un_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    k_q   <= k_d;
    n_q   <= n_d;
    sum_q <= sum_d;
    out_q <= out_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_ptr_q    <= '0;
      rd_ptr_q    <= '0;
      ov_q        <= 1'b0;
      un_q        <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_ptr_q    <= wr_ptr_d;
      rd_ptr_q    <= rd_ptr_d;
      ov_q        <= ov_d;
      un_q        <= un_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q <= LAST) && (rd_ptr_q <= LAST))
    else $error("ring pointer beyond depth");

  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.valid_result) |->
      (out_q.result_value == '0) && (out_q.result_stamp == '0))
    else $error("failed result carries data");

  a_div_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_busy |-> (state_q == ST_DIV))
    else $error("divider busy outside divide state");

  a_walk_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SUM) |-> (k_q <= n_q) && (n_q != '0))
    else $error("average walk past its length");

endmodule

### hdl/adc_sample_ring_with_average_top.sv
// Top level of the ADC sample ring with moving average.
//
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-------------------------
//  in      | into      | in_valid_i / in_ready_o   | in_data_i  (in_item_t)
//  out     | out of    | out_valid_o / out_ready_i | out_data_o (out_item_t)
//  cfg     | into      | cfg_we_i, no wait         | cfg_wdata_i (sample rate)
//
// An input transfer lands in a two-entry command queue, whose registered count
// presents it to the back end. In the back end push, status read, clear and
// unused modes finish in the idle state, a pop after a registered RAM read, and
// an average of N samples after one RAM read per sample, then a restoring divide
// of one quotient bit per cycle (SUM_W = 23 at the default depth).
// Reset empties the ring and clears both flags; the sample RAM is not cleared.
// The queue takes up to two transfers while a result waits on a stalled output.
module adc_sample_ring_with_average_top import asr_pkg::*; #(
  parameter int unsigned DEPTH = DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [RATE_W-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o
);

  // Sample rate: registered from the cfg port, no effect on the datapath
  logic [RATE_W-1:0] sample_rate_q;

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sample_rate_q <= '0;
    end else if (cfg_we_i) begin
      sample_rate_q <= cfg_wdata_i;
    end
  end

  // Decode and queue incoming commands
  asr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  // Execute commands against the ring and drive the result register
  asr_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule
